// File: rtl/motor_speed_calibration_sequencer_defines.svh
`ifndef MOTOR_SPEED_CALIBRATION_SEQUENCER_DEFINES_SVH
`define MOTOR_SPEED_CALIBRATION_SEQUENCER_DEFINES_SVH

// same-cycle implication check
`define MSCS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mscs check failed");

// next-cycle implication check
`define MSCS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mscs check failed");

`endif

// File: rtl/mscs_pkg.sv
`timescale 1ns / 1ps

package mscs_pkg;

    localparam int CFG_IDX_W = 3;
    localparam logic [16:0] TIMER_MAX = 17'h1FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ERROR_BAND     = 3'd0,
        CFG_SETTLE_MS      = 3'd1,
        CFG_FULL_POWER_MS  = 3'd2,
        CFG_SAMPLE_MS      = 3'd3,
        CFG_REFRESH_BAND   = 3'd4,
        CFG_FULL_BAND      = 3'd5,
        CFG_INTEGRAL_LIMIT = 3'd6,
        CFG_SPEED_STEP     = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_STOP_A   = 3'd1,
        PH_FWD      = 3'd2,
        PH_STOP_B   = 3'd3,
        PH_REV      = 3'd4,
        PH_STOP_END = 3'd5
    } t_phase;

    typedef struct packed {
        logic [7:0]  error_band;
        logic [15:0] settle_ms;
        logic [15:0] full_power_ms;
        logic [9:0]  sample_ms;
        logic [14:0] refresh_band;
        logic [14:0] full_band;
        logic [14:0] integral_limit;
        logic [7:0]  speed_step;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  point_index;
        logic [16:0] settle_timer;
        logic [16:0] full_timer;
        logic [1:0]  active_motor;
    } t_state;

    typedef struct packed {
        logic signed [11:0] setpoint;
        logic               write_enable;
        logic [1:0]         write_motor;
        logic [3:0]         write_first;
        logic [3:0]         write_final;
        logic signed [15:0] write_data;
        t_phase             phase;
        logic               done_res;
    } t_result;

endpackage

// File: rtl/mscs_cfg.sv
`timescale 1ns / 1ps

module mscs_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mscs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [15:0]                         i_cfg_data,
    output mscs_pkg::t_cfg                      o_cfg
);
    import mscs_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ERROR_BAND:     n_cfg.error_band     = i_cfg_data[7:0];
                CFG_SETTLE_MS:      n_cfg.settle_ms      = i_cfg_data;
                CFG_FULL_POWER_MS:  n_cfg.full_power_ms  = i_cfg_data;
                CFG_SAMPLE_MS:      n_cfg.sample_ms      = i_cfg_data[9:0];
                CFG_REFRESH_BAND:   n_cfg.refresh_band   = i_cfg_data[14:0];
                CFG_FULL_BAND:      n_cfg.full_band      = i_cfg_data[14:0];
                CFG_INTEGRAL_LIMIT: n_cfg.integral_limit = i_cfg_data[14:0];
                CFG_SPEED_STEP:     n_cfg.speed_step     = i_cfg_data[7:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.error_band     <= 8'd9;
            r_cfg.settle_ms      <= 16'd2000;
            r_cfg.full_power_ms  <= 16'd3000;
            r_cfg.sample_ms      <= 10'd50;
            r_cfg.refresh_band   <= 15'd30;
            r_cfg.full_band      <= 15'd10;
            r_cfg.integral_limit <= 15'd1000;
            r_cfg.speed_step     <= 8'd20;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// File: rtl/mscs_step.sv
`timescale 1ns / 1ps

module mscs_step #(
    parameter int NUM_MOTORS      = 4,
    parameter int POINTS_PER_SIDE = 5
) (
    input  mscs_pkg::t_cfg      i_cfg,
    input  mscs_pkg::t_state    i_cur,
    input  logic                i_req_type,
    input  logic [1:0]          i_motor_select,
    input  logic signed [12:0]  i_speed_error,
    input  logic signed [15:0]  i_integral_term,
    input  logic signed [15:0]  i_drive_value,
    output mscs_pkg::t_state    o_nxt,
    output mscs_pkg::t_result   o_res
);
    import mscs_pkg::*;

    localparam logic [3:0] PTS   = 4'(POINTS_PER_SIDE);
    localparam logic [3:0] SIDE2 = 4'(2 * POINTS_PER_SIDE);

    function automatic logic [16:0] sat_add(input logic [16:0] a, input logic [9:0] b);
        logic [17:0] s;
        s = {1'b0, a} + {8'd0, b};
        return s[17] ? TIMER_MAX : s[16:0];
    endfunction

    logic [12:0]        abs_err;
    logic               in_band;
    logic signed [17:0] lim_dist;
    logic [16:0]        abs_dist;
    logic [16:0]        ft_add;
    logic               ft_clr;
    logic               full_pwr;
    logic [16:0]        st_add;
    logic [3:0]         idx;
    logic               motor_ok;

    logic               wen;
    logic               done;
    logic [3:0]         wfirst;
    logic [3:0]         wfinal;
    logic [11:0]        sp_mag;

    assign abs_err  = i_speed_error[12] ? 13'(-i_speed_error) : 13'(i_speed_error);
    assign in_band  = abs_err <= {5'd0, i_cfg.error_band};
    assign lim_dist = $signed({3'd0, i_cfg.integral_limit})
                    - $signed({{2{i_integral_term[15]}}, i_integral_term});
    assign abs_dist = lim_dist[17] ? 17'(-lim_dist) : lim_dist[16:0];
    assign ft_add   = sat_add(i_cur.full_timer, i_cfg.sample_ms);
    assign ft_clr   = abs_dist > {2'd0, i_cfg.refresh_band};
    assign full_pwr = (abs_dist < {2'd0, i_cfg.full_band}) && !ft_clr
                    && (ft_add > {1'b0, i_cfg.full_power_ms});
    assign st_add   = in_band ? sat_add(i_cur.settle_timer, i_cfg.sample_ms) : 17'd0;
    assign idx      = (i_cur.phase == PH_FWD) ? PTS + i_cur.point_index
                                              : PTS - i_cur.point_index;
    assign motor_ok = 32'(i_motor_select) < NUM_MOTORS;

    // next state and write decision
    always_comb begin
        o_nxt  = i_cur;
        wen    = 1'b0;
        done   = 1'b0;
        wfirst = 4'd0;
        wfinal = 4'd0;
        if (i_req_type) begin
            if (motor_ok) begin
                o_nxt.active_motor = i_motor_select;
                o_nxt.phase        = PH_STOP_A;
                o_nxt.point_index  = 4'd0;
                o_nxt.settle_timer = 17'd0;
            end
        end else begin
            o_nxt.full_timer = ft_add;
            unique case (i_cur.phase)
                PH_STOP_A, PH_STOP_B: begin
                    if (in_band) begin
                        o_nxt.phase        = (i_cur.phase == PH_STOP_A) ? PH_FWD : PH_REV;
                        o_nxt.point_index  = 4'd1;
                        o_nxt.settle_timer = 17'd0;
                        if (ft_clr) begin
                            o_nxt.full_timer = 17'd0;
                        end
                        if (full_pwr) begin
                            wen = 1'b1;
                            if (i_cur.phase == PH_STOP_A) begin
                                wfirst      = PTS + 4'd1;
                                wfinal      = SIDE2;
                                o_nxt.phase = PH_STOP_B;
                            end else begin
                                wfirst      = 4'd0;
                                wfinal      = PTS - 4'd1;
                                o_nxt.phase = PH_STOP_END;
                            end
                            o_nxt.point_index = 4'd0;
                        end
                    end
                end
                PH_FWD, PH_REV: begin
                    o_nxt.settle_timer = st_add;
                    if (st_add > {1'b0, i_cfg.settle_ms}) begin
                        wen    = 1'b1;
                        wfirst = idx;
                        wfinal = idx;
                        if (i_cur.point_index >= PTS) begin
                            o_nxt.phase       = (i_cur.phase == PH_FWD) ? PH_STOP_B : PH_STOP_END;
                            o_nxt.point_index = 4'd0;
                        end else begin
                            o_nxt.point_index  = i_cur.point_index + 4'd1;
                            o_nxt.settle_timer = 17'd0;
                            if (ft_clr) begin
                                o_nxt.full_timer = 17'd0;
                            end
                            if (full_pwr) begin
                                if (i_cur.phase == PH_FWD) begin
                                    wfinal = SIDE2;
                                end else begin
                                    wfirst = 4'd0;
                                end
                                o_nxt.phase       = (i_cur.phase == PH_FWD) ? PH_STOP_B
                                                                            : PH_STOP_END;
                                o_nxt.point_index = 4'd0;
                            end
                        end
                    end else begin
                        if (ft_clr) begin
                            o_nxt.full_timer = 17'd0;
                        end
                        if (full_pwr) begin
                            wen = 1'b1;
                            if (i_cur.phase == PH_FWD) begin
                                wfirst = idx;
                                wfinal = SIDE2;
                            end else begin
                                wfirst = 4'd0;
                                wfinal = idx;
                            end
                            o_nxt.phase       = (i_cur.phase == PH_FWD) ? PH_STOP_B
                                                                        : PH_STOP_END;
                            o_nxt.point_index = 4'd0;
                        end
                    end
                end
                PH_STOP_END: begin
                    if (in_band) begin
                        o_nxt.phase = PH_IDLE;
                        done        = 1'b1;
                    end
                end
                default: o_nxt.phase = PH_IDLE;
            endcase
        end
    end

    assign sp_mag = {8'd0, o_nxt.point_index} * {4'd0, i_cfg.speed_step};

    // result formatting
    always_comb begin
        o_res = '0;
        unique case (o_nxt.phase)
            PH_FWD:  o_res.setpoint = $signed(sp_mag);
            PH_REV:  o_res.setpoint = $signed(12'(-sp_mag));
            default: o_res.setpoint = 12'sd0;
        endcase
        o_res.write_enable = wen;
        o_res.write_motor  = wen ? o_nxt.active_motor : 2'd0;
        o_res.write_first  = wen ? wfirst : 4'd0;
        o_res.write_final  = wen ? wfinal : 4'd0;
        o_res.write_data   = wen ? i_drive_value : 16'sd0;
        o_res.phase        = o_nxt.phase;
        o_res.done_res     = done;
    end

endmodule

// File: rtl/motor_speed_calibration_sequencer.sv
`timescale 1ns / 1ps
`include "motor_speed_calibration_sequencer_defines.svh"

// Motor speed calibration sequencer: a start transfer names a motor, every later input
// transfer is one speed-loop sample, and each input item gives exactly one result with the
// next setpoint, an optional range write of a drive value into the motor's table row, the
// phase and a done pulse. One item is taken every clock cycle while input stall is low; an
// item passes through the input register and the single-pass step logic into the result
// register, from which its result is offered. Input stall rises only while both registers hold
// items and the result side is stalled. Configuration registers may be written at any
// time the block is idle; all timing is counted in samples of sample_ms milliseconds.
module motor_speed_calibration_sequencer #(
    parameter int NUM_MOTORS      = 4,
    parameter int POINTS_PER_SIDE = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_req_type,
    input  logic [1:0]                      i_motor_select,
    input  logic signed [12:0]              i_speed_error,
    input  logic signed [15:0]              i_integral_term,
    input  logic signed [15:0]              i_drive_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [11:0]              o_setpoint,
    output logic                            o_write_enable,
    output logic [1:0]                      o_write_motor,
    output logic [3:0]                      o_write_first,
    output logic [3:0]                      o_write_final,
    output logic signed [15:0]              o_write_data,
    output logic [2:0]                      o_phase,
    output logic                            o_done_res,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mscs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [15:0]                     i_cfg_data
);
    import mscs_pkg::*;

    t_cfg    cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_res;
    t_result r_res;

    logic               r_in_vld;
    logic               r_req;
    logic [1:0]         r_msel;
    logic signed [12:0] r_err;
    logic signed [15:0] r_integ;
    logic signed [15:0] r_drive;
    logic               r_out_vld;
    logic               adv;
    logic               take;

    mscs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mscs_step #(
        .NUM_MOTORS      (NUM_MOTORS),
        .POINTS_PER_SIDE (POINTS_PER_SIDE)
    ) u_step (
        .i_cfg           (cfg),
        .i_cur           (r_state),
        .i_req_type      (r_req),
        .i_motor_select  (r_msel),
        .i_speed_error   (r_err),
        .i_integral_term (r_integ),
        .i_drive_value   (r_drive),
        .o_nxt           (n_state),
        .o_res           (n_res)
    );

    assign adv        = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_in_vld && !adv;
    assign take       = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_req   <= i_req_type;
            r_msel  <= i_motor_select;
            r_err   <= i_speed_error;
            r_integ <= i_integral_term;
            r_drive <= i_drive_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase        <= PH_IDLE;
            r_state.point_index  <= 4'd0;
            r_state.settle_timer <= 17'd0;
            r_state.full_timer   <= TIMER_MAX;
            r_state.active_motor <= 2'd0;
            r_out_vld            <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_in_vld;
            if (r_in_vld) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_vld) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_setpoint     = r_res.setpoint;
    assign o_write_enable = r_res.write_enable;
    assign o_write_motor  = r_res.write_motor;
    assign o_write_first  = r_res.write_first;
    assign o_write_final  = r_res.write_final;
    assign o_write_data   = r_res.write_data;
    assign o_phase        = r_res.phase;
    assign o_done_res     = r_res.done_res;

    `MSCS_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_out_valid && o_done_res, o_phase == PH_IDLE)
    `MSCS_ASSERT_IMP(a_range_order, i_clk, i_rst_n, o_out_valid && o_write_enable, o_write_first <= o_write_final)
    `MSCS_ASSERT_IMP(a_sp_zero, i_clk, i_rst_n, o_out_valid && o_phase != PH_FWD && o_phase != PH_REV, o_setpoint == 12'sd0)
    `MSCS_ASSERT_NXT(a_held_result, i_clk, i_rst_n, r_out_vld && i_out_stall, r_out_vld && $stable(r_res))

endmodule
